// ===== hdl/deq_pkg.sv =====
package deq_pkg;

  // Request kinds.
  localparam int KIND_W = 3;
  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_PUSH_FRONT = 3'd0;
  localparam kind_t KIND_PUSH_BACK  = 3'd1;
  localparam kind_t KIND_POP_FRONT  = 3'd2;
  localparam kind_t KIND_POP_BACK   = 3'd3;
  localparam kind_t KIND_DUMP_FWD   = 3'd4;
  localparam kind_t KIND_DUMP_BWD   = 3'd5;

  // Result status codes.
  localparam int STATUS_W = 2;
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  // Field widths.
  localparam int DATA_W = 32;
  localparam int OCC_W  = 7;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [OCC_W-1:0] occ_t;

  // One result as held in the output queue.
  typedef struct packed {
    data_t   value;
    status_t status;
    logic    last;
    occ_t    occupancy;
  } rsp_t;

endpackage

// ===== hdl/deq_if.sv =====
// Request channel: one queue operation per request.
interface deq_req_if;
  logic                  valid;
  logic                  ready;
  deq_pkg::kind_t        kind;
  deq_pkg::data_t        push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink (input valid, input kind, input push_value, output ready);
endinterface

// Result channel: one status or entry per result; a dump yields one result per entry.
interface deq_rsp_if;
  logic                  valid;
  logic                  ready;
  deq_pkg::data_t        out_value;
  deq_pkg::status_t      status;
  logic                  last;
  deq_pkg::occ_t         occupancy;

  modport source (output valid, output out_value, output status, output last,
                  output occupancy, input ready);
  modport sink (input valid, input out_value, input status, input last,
                input occupancy, output ready);
endinterface

// ===== hdl/double_ended_queue_core.sv =====
// Channel   Port     Dir  Contents
// request   in_req   in   kind, push_value
// result    out_rsp  out  out_value, status, last, occupancy
//
// A push, a pop or a rejected request passes through the result stage register and
// then a two-entry output queue before its result is offered.
// A dump of N entries holds the request side until its last read, one read of the
// entry memory per cycle while the output side has space, and streams N results.
// Reset (rst_n low, synchronous) empties the queue; memory contents are not cleared.
// A stalled result side stops memory reads once the output queue and the
// read in flight fill it; no result is dropped.
module double_ended_queue_core #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  deq_req_if.sink           in_req,
  deq_rsp_if.source         out_rsp
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  // Queue pointers and dump sequencer.
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] back_r, back_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             state_r, state_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             fwd_r, fwd_nxt;

  // Entry memory.
  deq_pkg::data_t   mem [DEPTH];
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  deq_pkg::data_t   rd_data_r;

  // Result stage, aligned with the memory read data.
  logic             issue;
  logic             iss_rd;
  deq_pkg::status_t iss_status;
  logic             iss_last;
  logic [CNT_W-1:0] iss_occ;
  logic             res_valid_r;
  logic             res_rd_r;
  deq_pkg::status_t res_status_r;
  logic             res_last_r;
  logic [CNT_W-1:0] res_occ_r;

  // Output queue.
  deq_pkg::rsp_t    fifo_q [2];
  logic             fifo_wptr_r;
  logic             fifo_rptr_r;
  logic [1:0]       fifo_cnt_r;
  logic             deq;
  logic [2:0]       pend;
  logic             room;
  logic             acc;
  deq_pkg::rsp_t    head;

  // Space check: results already queued or in flight must leave a free slot.
  assign deq  = (fifo_cnt_r != 2'd0) && out_rsp.ready;
  assign pend = {1'b0, fifo_cnt_r} + {2'b00, res_valid_r} - {2'b00, deq};
  assign room = (pend < 3'd2);

  assign in_req.ready = (state_r == S_IDLE) && room;
  assign acc          = in_req.valid && in_req.ready;

  // Request decode and dump stepping.
  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    left_nxt   = left_r;
    fwd_nxt    = fwd_r;
    mem_we     = 1'b0;
    mem_waddr  = back_r;
    mem_re     = 1'b0;
    mem_raddr  = front_r;
    issue      = 1'b0;
    iss_rd     = 1'b0;
    iss_status = deq_pkg::ST_OK;
    iss_last   = 1'b1;
    iss_occ    = count_r;

    if (state_r == S_IDLE) begin
      if (acc) begin
        case (in_req.kind)
          deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
            issue = 1'b1;
            if (count_r == FULL_CNT) begin
              iss_status = deq_pkg::ST_FULL;
            end else begin
              mem_we = 1'b1;
              if (in_req.kind == deq_pkg::KIND_PUSH_FRONT) begin
                mem_waddr = idx_prev(front_r);
                front_nxt = idx_prev(front_r);
              end else begin
                mem_waddr = back_r;
                back_nxt  = idx_next(back_r);
              end
              count_nxt = count_r + 1'b1;
              iss_occ   = count_r + 1'b1;
            end
          end
          deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK: begin
            issue = 1'b1;
            if (count_r == '0) begin
              iss_status = deq_pkg::ST_EMPTY;
            end else begin
              mem_re = 1'b1;
              iss_rd = 1'b1;
              if (in_req.kind == deq_pkg::KIND_POP_FRONT) begin
                mem_raddr = front_r;
                front_nxt = idx_next(front_r);
              end else begin
                mem_raddr = idx_prev(back_r);
                back_nxt  = idx_prev(back_r);
              end
              count_nxt = count_r - 1'b1;
              iss_occ   = count_r - 1'b1;
            end
          end
          deq_pkg::KIND_DUMP_FWD, deq_pkg::KIND_DUMP_BWD: begin
            if (count_r == '0) begin
              issue      = 1'b1;
              iss_status = deq_pkg::ST_EMPTY;
            end else begin
              state_nxt = S_DUMP;
              fwd_nxt   = (in_req.kind == deq_pkg::KIND_DUMP_FWD);
              pos_nxt   = (in_req.kind == deq_pkg::KIND_DUMP_FWD) ? front_r
                                                                   : idx_prev(back_r);
              left_nxt  = count_r;
            end
          end
          default: begin
            issue = 1'b0;
          end
        endcase
      end
    end else if (room) begin
      // One entry read per cycle while the output side has space.
      mem_re    = 1'b1;
      mem_raddr = pos_r;
      issue     = 1'b1;
      iss_rd    = 1'b1;
      iss_last  = (left_r == CNT_W'(1));
      pos_nxt   = fwd_r ? idx_next(pos_r) : idx_prev(pos_r);
      left_nxt  = left_r - 1'b1;
      if (left_r == CNT_W'(1)) begin
        state_nxt = S_IDLE;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      back_r      <= '0;
      count_r     <= '0;
      state_r     <= S_IDLE;
      left_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      count_r     <= count_nxt;
      state_r     <= state_nxt;
      left_r      <= left_nxt;
      res_valid_r <= issue;
    end
  end

  // Payload registers of the sequencer and the result stage.
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    fwd_r        <= fwd_nxt;
    res_rd_r     <= iss_rd;
    res_status_r <= iss_status;
    res_last_r   <= iss_last;
    res_occ_r    <= iss_occ;
  end

  // Entry memory write port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_req.push_value;
    end
  end

  // Entry memory registered read port.
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Output queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_wptr_r <= 1'b0;
      fifo_rptr_r <= 1'b0;
      fifo_cnt_r  <= 2'd0;
    end else begin
      if (res_valid_r) begin
        fifo_wptr_r <= ~fifo_wptr_r;
      end
      if (deq) begin
        fifo_rptr_r <= ~fifo_rptr_r;
      end
      fifo_cnt_r <= fifo_cnt_r + {1'b0, res_valid_r} - {1'b0, deq};
    end
  end

  // Output queue storage; a result with no entry carries zero.
  always_ff @(posedge clk) begin
    if (res_valid_r) begin
      fifo_q[fifo_wptr_r] <= '{value:     res_rd_r ? rd_data_r : '0,
                               status:    res_status_r,
                               last:      res_last_r,
                               occupancy: deq_pkg::OCC_W'(res_occ_r)};
    end
  end

  assign head              = fifo_q[fifo_rptr_r];
  assign out_rsp.valid     = (fifo_cnt_r != 2'd0);
  assign out_rsp.out_value = head.value;
  assign out_rsp.status    = head.status;
  assign out_rsp.last      = head.last;
  assign out_rsp.occupancy = head.occupancy;

  // The entry count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above capacity");

  // The back index always sits count entries past the front index.
  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    ((({1'b0, front_r} + count_r) >= FULL_CNT) ?
      (({1'b0, front_r} + count_r - FULL_CNT) == {1'b0, back_r}) :
      (({1'b0, front_r} + count_r) == {1'b0, back_r})))
    else $error("front, back and count disagree");

  // A result leaving the result stage always finds a free queue slot.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> (fifo_cnt_r < 2'd2) || deq)
    else $error("output queue overflow");

  // A dump never reads past its remaining entry count.
  a_dump_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> (left_r != '0) && (left_r <= count_r))
    else $error("dump sequencer out of range");

  // No new request is taken while a dump is streaming.
  a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> !in_req.ready)
    else $error("request accepted during dump");

endmodule
